[rtl/rbls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rbls_pkg;

  localparam int SRC_WIDTH_DEF    = 128;
  localparam int SRC_HEIGHT_DEF   = 128;
  localparam int PANEL_WIDTH_DEF  = 256;
  localparam int PANEL_HEIGHT_DEF = 256;

  localparam int COORD_W = 8;
  localparam int PIXEL_W = 16;
  localparam int DEST_W  = 9;
  localparam int STEP_W  = 24;
  localparam int CFG_W   = 24;
  localparam int FP_W    = COORD_W + STEP_W;

  localparam logic [15:0] MASK_RB = 16'hF81F;
  localparam logic [15:0] MASK_G  = 16'h07E0;
  localparam logic [5:0]  WEIGHT_ONE = 6'd32;

  localparam logic [DEST_W-1:0] DEST_RESET = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd32768;

  typedef enum logic [1:0] {
    CFG_DEST_WIDTH  = 2'd0,
    CFG_DEST_HEIGHT = 2'd1,
    CFG_STEP_X      = 2'd2,
    CFG_STEP_Y      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DEST_W-1:0] dest_width;
    logic [DEST_W-1:0] dest_height;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
  } cfg_t;

  // Classified item: flag is "inside window" for a request and
  // "within source" for a load; u/v are window offsets or source coords.
  typedef struct packed {
    logic               is_req;
    logic               flag;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic [PIXEL_W-1:0] pix;
  } item_t;

endpackage

`default_nettype wire

[rtl/rbls_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rbls_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  coord_x;
  logic [7:0]  coord_y;
  logic [15:0] pixel_in;

  modport source (output valid, req_type, coord_x, coord_y, pixel_in, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, pixel_in, output ready);
endinterface

interface rbls_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic        inside_picture;

  modport source (output valid, pixel_out, inside_picture, input ready);
  modport sink   (input valid, pixel_out, inside_picture, output ready);
endinterface

`default_nettype wire

[rtl/rbls_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbls_front
  import rbls_pkg::*;
#(
  parameter int SRC_WIDTH    = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT   = SRC_HEIGHT_DEF,
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  cfg_t               cfg_i,
  input  logic               req_type_i,
  input  logic [COORD_W-1:0] coord_x_i,
  input  logic [COORD_W-1:0] coord_y_i,
  input  logic [PIXEL_W-1:0] pixel_i,
  output item_t              item_o
);

  localparam int PXB = $clog2(PANEL_WIDTH + 1);
  localparam int PYB = $clog2(PANEL_HEIGHT + 1);
  localparam int XW  = ((PXB > DEST_W) ? PXB : DEST_W) + 1;
  localparam int YW  = ((PYB > DEST_W) ? PYB : DEST_W) + 1;

  logic [XW-1:0] sx, offx, px, dx;
  logic [YW-1:0] sy, offy, py, dy;
  logic          in_x, in_y, load_ok;

  always_comb begin
    // clamp window to panel, center it
    sx   = (XW'(cfg_i.dest_width) > XW'(PANEL_WIDTH)) ? XW'(PANEL_WIDTH)
                                                       : XW'(cfg_i.dest_width);
    sy   = (YW'(cfg_i.dest_height) > YW'(PANEL_HEIGHT)) ? YW'(PANEL_HEIGHT)
                                                         : YW'(cfg_i.dest_height);
    offx = (XW'(PANEL_WIDTH) - sx) >> 1;
    offy = (YW'(PANEL_HEIGHT) - sy) >> 1;
    px   = XW'(coord_x_i);
    py   = YW'(coord_y_i);
    in_x = (px >= offx) && (px < offx + sx);
    in_y = (py >= offy) && (py < offy + sy);
    dx   = px - offx;
    dy   = py - offy;
    load_ok = (px < XW'(SRC_WIDTH)) && (py < YW'(SRC_HEIGHT));

    item_o.is_req = req_type_i;
    item_o.flag   = req_type_i ? (in_x && in_y) : load_ok;
    item_o.u      = req_type_i ? dx[COORD_W-1:0] : coord_x_i;
    item_o.v      = req_type_i ? dy[COORD_W-1:0] : coord_y_i;
    item_o.pix    = pixel_i;
  end

endmodule

`default_nettype wire

[rtl/rbls_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbls_queue
  import rbls_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t       slot_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  assign full_o  = cnt_q[2];
  assign valid_o = (cnt_q != 3'd0);
  assign item_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 3'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= wr_q + 2'd1;
      if (do_pop)  rd_q <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= item_i;
  end

endmodule

`default_nettype wire

[rtl/rbls_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbls_back
  import rbls_pkg::*;
#(
  parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = SRC_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               valid_i,
  input  item_t              item_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [PIXEL_W-1:0] pixel_o,
  output logic               inside_o
);

  localparam int XW = (SRC_WIDTH  > 2) ? $clog2(SRC_WIDTH)  : 1;
  localparam int YW = (SRC_HEIGHT > 2) ? $clog2(SRC_HEIGHT) : 1;
  localparam int HW = (SRC_WIDTH  + 1) / 2;
  localparam int HH = (SRC_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HW * HH;
  localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  function automatic logic [20:0] mix(input logic [15:0] a, input logic [15:0] b,
                                      input logic [5:0] wa, input logic [5:0] wb,
                                      input logic [15:0] m);
    mix = 21'(a & m) * 21'(wa) + 21'(b & m) * 21'(wb);
  endfunction

  logic en;
  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  // stage 1: source coordinate products
  logic              v1_q;
  item_t             it1_q;
  logic [FP_W-1:0]   fpx1_q, fpy1_q;

  // stage 2: clamp, bank addressing, frame read/write
  logic [15:0]   ipx, ipy, ux, uy;
  logic [XW-1:0] ax, x0, x1;
  logic [YW-1:0] ay, y0, y1;
  logic [4:0]    fx, fy;
  logic [AW-1:0] addr [4];
  logic [3:0]    we;
  logic [15:0]   rd_q [4];
  logic          v2_q, req2_q, in2_q;
  logic          x0p_q, x1p_q, y0p_q, y1p_q;
  logic [4:0]    fx2_q, fy2_q;

  // stage 3: horizontal blend
  logic [15:0]   p00, p01, p10, p11;
  logic [5:0]    ifx, ify;
  logic          v3_q, req3_q, in3_q;
  logic [4:0]    fy3_q;
  logic [20:0]   trb_q, tg_q, brb_q, bg_q;

  // stage 4: vertical blend into the output register
  logic [25:0]   rb, g;
  logic [15:0]   pix_d;
  logic          v4_q;
  logic [15:0]   pix_q;
  logic          in4_q;

  always_comb begin
    ipx = fpx1_q[FP_W-1:16];
    ipy = fpy1_q[FP_W-1:16];
    ux  = 16'(it1_q.u);
    uy  = 16'(it1_q.v);
    ax  = (ipx >= 16'(SRC_WIDTH))  ? XW'(SRC_WIDTH - 1)  : ipx[XW-1:0];
    ay  = (ipy >= 16'(SRC_HEIGHT)) ? YW'(SRC_HEIGHT - 1) : ipy[YW-1:0];
    if (it1_q.is_req) begin
      x0 = ax;
      x1 = (ax == XW'(SRC_WIDTH - 1))  ? ax : ax + 1'b1;
      y0 = ay;
      y1 = (ay == YW'(SRC_HEIGHT - 1)) ? ay : ay + 1'b1;
      fx = fpx1_q[15:11];
      fy = fpy1_q[15:11];
    end else begin
      x0 = ux[XW-1:0];
      x1 = ux[XW-1:0];
      y0 = uy[YW-1:0];
      y1 = uy[YW-1:0];
      fx = '0;
      fy = '0;
    end
  end

  // four banks by column/row parity; the 2x2 neighbors hit each bank once
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [15:0]   mem [BANK_DEPTH];
    logic [XW-1:0] c;
    logic [YW-1:0] r, rh;
    logic [XW-1:0] ch;

    always_comb begin
      c     = (x0[0] == b[0]) ? x0 : x1;
      r     = (y0[0] == b[1]) ? y0 : y1;
      ch    = c >> 1;
      rh    = r >> 1;
      addr[b] = AW'(rh) * AW'(HW) + AW'(ch);
      we[b] = v1_q && !it1_q.is_req && it1_q.flag &&
              (x0[0] == b[0]) && (y0[0] == b[1]);
    end

    always_ff @(posedge clk_i) begin
      if (en && we[b]) mem[addr[b]] <= it1_q.pix;
      if (en) rd_q[b] <= mem[addr[b]];
    end
  end

  always_comb begin
    p00 = rd_q[{y0p_q, x0p_q}];
    p01 = rd_q[{y0p_q, x1p_q}];
    p10 = rd_q[{y1p_q, x0p_q}];
    p11 = rd_q[{y1p_q, x1p_q}];
    ifx = WEIGHT_ONE - {1'b0, fx2_q};
    ify = WEIGHT_ONE - {1'b0, fy3_q};
    rb  = 26'(trb_q) * 26'(ify) + 26'(brb_q) * 26'(fy3_q);
    g   = 26'(tg_q)  * 26'(ify) + 26'(bg_q)  * 26'(fy3_q);
    pix_d = (rb[25:10] & MASK_RB) | (g[25:10] & MASK_G);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q && req3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q  <= item_i;
      fpx1_q <= FP_W'(item_i.u) * FP_W'(cfg_i.step_x);
      fpy1_q <= FP_W'(item_i.v) * FP_W'(cfg_i.step_y);

      req2_q <= it1_q.is_req;
      in2_q  <= it1_q.flag;
      x0p_q  <= x0[0];
      x1p_q  <= x1[0];
      y0p_q  <= y0[0];
      y1p_q  <= y1[0];
      fx2_q  <= fx;
      fy2_q  <= fy;

      req3_q <= req2_q;
      in3_q  <= in2_q;
      fy3_q  <= fy2_q;
      trb_q  <= mix(p00, p01, ifx, {1'b0, fx2_q}, MASK_RB);
      tg_q   <= mix(p00, p01, ifx, {1'b0, fx2_q}, MASK_G);
      brb_q  <= mix(p10, p11, ifx, {1'b0, fx2_q}, MASK_RB);
      bg_q   <= mix(p10, p11, ifx, {1'b0, fx2_q}, MASK_G);

      pix_q  <= in3_q ? pix_d : '0;
      in4_q  <= in3_q;
    end
  end

  assign valid_o  = v4_q;
  assign pixel_o  = pix_q;
  assign inside_o = in4_q;

endmodule

`default_nettype wire

[rtl/rgb565_bilinear_letterbox_scaler.sv]
// Channel  Dir  Handshake            Payload
// in_i     in   in_i.valid/ready     req_type, coord_x, coord_y, pixel_in
// out_o    out  out_o.valid/ready    pixel_out, inside_picture
// cfg      in   cfg_we_i             cfg_idx_i, cfg_data_i (write only)
//
// One item per clock sustained while results are taken; the four neighbor reads come from four
// parity banks of the source frame, one read port each.
// A request's result passes the product, frame-read, horizontal-blend and output registers; loads give none.
// Reset clears control state only; frame contents are undefined until loaded.
// A 4-entry queue parts input from the back pipeline; the back pipeline
// halts as a whole only while its output register holds an untaken result.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_bilinear_letterbox_scaler
  import rbls_pkg::*;
#(
  parameter int SRC_WIDTH    = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT   = SRC_HEIGHT_DEF,
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rbls_in_if.sink          in_i,
  rbls_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t fr_item, q_item;
  logic  q_full, q_valid, bk_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_width  <= DEST_RESET;
      cfg_q.dest_height <= DEST_RESET;
      cfg_q.step_x      <= STEP_RESET;
      cfg_q.step_y      <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEST_WIDTH:  cfg_q.dest_width  <= cfg_data_i[DEST_W-1:0];
        CFG_DEST_HEIGHT: cfg_q.dest_height <= cfg_data_i[DEST_W-1:0];
        CFG_STEP_X:      cfg_q.step_x      <= cfg_data_i[STEP_W-1:0];
        CFG_STEP_Y:      cfg_q.step_y      <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // front: window test and offsets, or load range check
  rbls_front #(
    .SRC_WIDTH   (SRC_WIDTH),
    .SRC_HEIGHT  (SRC_HEIGHT),
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_front (
    .cfg_i     (cfg_q),
    .req_type_i(in_i.req_type),
    .coord_x_i (in_i.coord_x),
    .coord_y_i (in_i.coord_y),
    .pixel_i   (in_i.pixel_in),
    .item_o    (fr_item)
  );

  assign in_i.ready = !q_full;

  rbls_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_i.valid),
    .item_i (fr_item),
    .full_o (q_full),
    .pop_i  (bk_ready),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  // back: coordinate products, banked frame access, two blend stages
  rbls_back #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (q_valid),
    .item_i  (q_item),
    .ready_o (bk_ready),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .pixel_o (out_o.pixel_out),
    .inside_o(out_o.inside_picture)
  );

endmodule

`default_nettype wire

[rtl/rbls_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rbls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] pixel_out_i,
  input logic        inside_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(pixel_out_i) && $stable(inside_i))
    else $error("stalled result changed");

  a_black_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !inside_i |-> pixel_out_i == 16'd0)
    else $error("pixel outside window is not black");

  a_ready_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_ready_i && !out_valid_i)
    else $error("queue not empty after reset");

endmodule

bind rgb565_bilinear_letterbox_scaler rbls_checker u_rbls_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .pixel_out_i(out_o.pixel_out),
  .inside_i   (out_o.inside_picture)
);

`default_nettype wire
